/* src/anc_pkg.sv */
package anc_pkg;

    localparam int VALUE_WIDTH = 31;
    // trial divisor counter: reaches floor(sqrt(n)) + 1
    localparam int D_W   = (VALUE_WIDTH + 1) / 2 + 1;
    // proper divisor sum stays below 7 * n
    localparam int ACC_W = VALUE_WIDTH + 3;
    localparam int OUT_W = 34;
    localparam int EXT_W = (ACC_W > OUT_W) ? ACC_W : OUT_W;
    localparam int CNT_W = $clog2(VALUE_WIDTH);

    localparam logic [OUT_W-1:0] OUT_MAX   = '1;
    localparam logic [D_W-1:0]   D_FIRST   = D_W'(2);
    localparam logic [CNT_W-1:0] CNT_START = CNT_W'(VALUE_WIDTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_CHECK,
        ST_ADD_Q,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic div_load;
        logic div_step;
        logic add_d;
        logic add_q;
        logic next_d;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic n_small;
        logic div_last;
        logic d_gt_q;
        logic rem_zero;
        logic q_eq_d;
    } t_dp_sts;

    function automatic logic [OUT_W-1:0] sat_out(input logic [ACC_W-1:0] x);
        logic [EXT_W-1:0] xe;
        xe = EXT_W'(x);
        return (xe > EXT_W'(OUT_MAX)) ? OUT_MAX : OUT_W'(xe);
    endfunction

endpackage

/* src/anc_ctrl.sv */
module anc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    input  anc_pkg::t_dp_sts i_sts,
    output anc_pkg::t_dp_cmd o_cmd
);

    anc_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= anc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            anc_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = anc_pkg::ST_PREP;
                end
            end
            anc_pkg::ST_PREP: begin
                if (i_sts.n_small) begin
                    n_state = anc_pkg::ST_DONE;
                end else begin
                    o_cmd.div_load = 1'b1;
                    n_state        = anc_pkg::ST_DIV;
                end
            end
            anc_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = anc_pkg::ST_CHECK;
                end
            end
            anc_pkg::ST_CHECK: begin
                if (i_sts.d_gt_q) begin
                    n_state = anc_pkg::ST_DONE;
                end else if (i_sts.rem_zero && !i_sts.q_eq_d) begin
                    o_cmd.add_d = 1'b1;
                    n_state     = anc_pkg::ST_ADD_Q;
                end else begin
                    o_cmd.add_d    = i_sts.rem_zero;
                    o_cmd.next_d   = 1'b1;
                    o_cmd.div_load = 1'b1;
                    n_state        = anc_pkg::ST_DIV;
                end
            end
            anc_pkg::ST_ADD_Q: begin
                o_cmd.add_q    = 1'b1;
                o_cmd.next_d   = 1'b1;
                o_cmd.div_load = 1'b1;
                n_state        = anc_pkg::ST_DIV;
            end
            anc_pkg::ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = anc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = anc_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == anc_pkg::ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

/* src/anc_dpath.sv */
module anc_dpath (
    input  logic                            i_clk,
    input  logic [anc_pkg::VALUE_WIDTH-1:0] i_value,
    input  anc_pkg::t_dp_cmd                i_cmd,
    output anc_pkg::t_dp_sts                o_sts,
    output logic [anc_pkg::OUT_W-1:0]       o_divisor_sum,
    output logic                            o_is_abundant,
    output logic [anc_pkg::OUT_W-1:0]       o_abundance
);

    logic [anc_pkg::VALUE_WIDTH-1:0] r_n;
    logic [anc_pkg::D_W-1:0]         r_d;
    logic [anc_pkg::ACC_W-1:0]       r_acc;
    logic [anc_pkg::D_W-1:0]         r_rem;
    logic [anc_pkg::VALUE_WIDTH-1:0] r_quo;
    logic [anc_pkg::CNT_W-1:0]       r_cnt;
    logic [anc_pkg::OUT_W-1:0]       r_sum_out;
    logic                            r_abund_out;
    logic [anc_pkg::OUT_W-1:0]       r_diff_out;

    logic [anc_pkg::D_W:0]           trial;
    logic                            fits;
    logic [anc_pkg::D_W:0]           trial_sub;
    logic [anc_pkg::ACC_W-1:0]       n_ext;
    logic                            over;
    logic [anc_pkg::ACC_W-1:0]       diff;

    // restoring divide, one quotient bit per cycle
    assign trial     = {r_rem, r_quo[anc_pkg::VALUE_WIDTH-1]};
    assign fits      = (trial >= {1'b0, r_d});
    assign trial_sub = trial - {1'b0, r_d};

    assign n_ext = anc_pkg::ACC_W'(r_n);
    assign over  = (r_acc > n_ext);
    assign diff  = r_acc - n_ext;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_n   <= i_value;
            r_acc <= (i_value[anc_pkg::VALUE_WIDTH-1:1] == '0) ? '0 : anc_pkg::ACC_W'(1);
            r_d   <= anc_pkg::D_FIRST;
        end
        if (i_cmd.div_load) begin
            r_rem <= '0;
            r_quo <= r_n;
            r_cnt <= anc_pkg::CNT_START;
        end else if (i_cmd.div_step) begin
            r_rem <= fits ? trial_sub[anc_pkg::D_W-1:0] : trial[anc_pkg::D_W-1:0];
            r_quo <= {r_quo[anc_pkg::VALUE_WIDTH-2:0], fits};
            r_cnt <= r_cnt - anc_pkg::CNT_W'(1);
        end
        if (i_cmd.add_d) begin
            r_acc <= r_acc + anc_pkg::ACC_W'(r_d);
        end else if (i_cmd.add_q) begin
            r_acc <= r_acc + anc_pkg::ACC_W'(r_quo);
        end
        if (i_cmd.next_d) begin
            r_d <= r_d + anc_pkg::D_W'(1);
        end
        if (i_cmd.load_out) begin
            r_sum_out   <= anc_pkg::sat_out(r_acc);
            r_abund_out <= over;
            r_diff_out  <= over ? anc_pkg::sat_out(diff) : '0;
        end
    end

    assign o_sts.n_small  = (r_n[anc_pkg::VALUE_WIDTH-1:1] == '0);
    assign o_sts.div_last = (r_cnt == '0);
    assign o_sts.d_gt_q   = (anc_pkg::VALUE_WIDTH'(r_d) > r_quo);
    assign o_sts.rem_zero = (r_rem == '0);
    assign o_sts.q_eq_d   = (anc_pkg::VALUE_WIDTH'(r_d) == r_quo);

    assign o_divisor_sum = r_sum_out;
    assign o_is_abundant = r_abund_out;
    assign o_abundance   = r_diff_out;

endmodule

/* src/abundant_number_classifier_top.sv */
// sums the proper divisors of one value by trial division and flags whether
// the value is abundant. each candidate d = 2, 3, ... is divided into the value
// by a shared bit-serial restoring divider, one quotient bit per cycle, and a
// candidate that divides evenly with a cofactor distinct from d passes through
// an add state for the cofactor. candidates run up to floor(sqrt(value)) + 1;
// values 0 and 1 skip the loop and report a zero sum. one item is worked on at
// a time; the result sits in an output register, so the next value beat is
// taken as soon as the loop is free, even while the previous result is still
// waiting for the sink
module abundant_number_classifier_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // value channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [anc_pkg::VALUE_WIDTH-1:0] i_value,
    // result channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [anc_pkg::OUT_W-1:0]       o_divisor_sum,
    output logic                            o_is_abundant,
    output logic [anc_pkg::OUT_W-1:0]       o_abundance
);

    // command and status between the sequencer and the datapath
    anc_pkg::t_dp_cmd cmd;
    anc_pkg::t_dp_sts sts;

    // sequencer: walks the candidate loop and owns both handshakes
    anc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath: divider, candidate counter, sum accumulator, result register
    anc_dpath u_dpath (
        .i_clk         (i_clk),
        .i_value       (i_value),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_divisor_sum (o_divisor_sum),
        .o_is_abundant (o_is_abundant),
        .o_abundance   (o_abundance)
    );

    // abundance is nonzero exactly when the flag is set
    a_flag_matches_abundance: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_abundant == (o_abundance != '0))
    ) else $error("abundance and flag disagree");

    // the sum is never below the abundance it yields
    a_sum_covers_abundance: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_abundant) |-> (o_divisor_sum >= o_abundance)
    ) else $error("divisor sum below abundance");

    // an accepted value beat makes the loop busy on the next cycle
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready
    ) else $error("input still ready after accepting a beat");

    // a result is only loaded from the done state
    a_load_from_done: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (u_ctrl.r_state == anc_pkg::ST_DONE)
    ) else $error("result loaded outside done state");

endmodule

/* test/tb_abundant_number_classifier_top.sv */
module tb_abundant_number_classifier_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_WIDTH = anc_pkg::VALUE_WIDTH;
    localparam int OUT_W       = anc_pkg::OUT_W;

    // one item with a full-width value runs the whole divisor loop with no beat
    // on either side, so the silence limit must cover that whole loop
    localparam int unsigned SILENCE_LIMIT = 6_000_000;
    // an item on a value of 0 or 1 skips the divisor loop
    localparam int unsigned DRAIN_CYCLES  = 20;
    localparam int unsigned REPORT_LIMIT  = 10;

    // what the block reports for one value
    typedef struct packed {
        logic [OUT_W-1:0] divisor_sum;
        logic             is_abundant;
        logic [OUT_W-1:0] abundance;
    } t_divisor_report;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic [VALUE_WIDTH-1:0] i_value;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [OUT_W-1:0]       o_divisor_sum;
    logic                   o_is_abundant;
    logic [OUT_W-1:0]       o_abundance;

    // reports still owed by the block, oldest first
    t_divisor_report pending_reports[$];
    int unsigned     mismatch_count = 0;
    int unsigned     silent_cycles  = 0;
    // random gaps and stalls, switched off for the closing stretch
    bit              idling_on      = 1'b1;
    int unsigned     ready_burst    = 0;

    abundant_number_classifier_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_divisor_sum (o_divisor_sum),
        .o_is_abundant (o_is_abundant),
        .o_abundance   (o_abundance)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // 64-bit add that sticks at all ones instead of wrapping
    function automatic longint unsigned clamp_add(input longint unsigned a,
                                                  input longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s < a) ? '1 : s;
    endfunction

    // squeeze a 64-bit total into the 34-bit result fields
    function automatic logic [OUT_W-1:0] clamp_out(input longint unsigned x);
        longint unsigned top;
        top = (64'd1 << OUT_W) - 64'd1;
        return (x > top) ? OUT_W'(top) : OUT_W'(x);
    endfunction

    // trial division: every d with d*d <= n that divides n adds d and its
    // cofactor, the cofactor only when it differs from d; 0 and 1 give nothing
    function automatic t_divisor_report classify_value(input logic [VALUE_WIDTH-1:0] value);
        longint unsigned n;
        longint unsigned total;
        longint unsigned d;
        longint unsigned q;
        t_divisor_report r;
        n = longint'(value);
        total = 0;
        if (n >= 2) begin
            total = 1;
            for (d = 2; d <= n / d; d++) begin
                if (n % d == 0) begin
                    q = n / d;
                    total = clamp_add(total, d);
                    if (q != d) begin
                        total = clamp_add(total, q);
                    end
                end
            end
        end
        r.divisor_sum = clamp_out(total);
        r.is_abundant = (total > n);
        r.abundance   = (total > n) ? clamp_out(total - n) : '0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // value side
    // ------------------------------------------------------------------

    // offer one value beat and hold it until taken; valid is lowered only
    // for a gap, so back-to-back beats never see a low-high pair in one step
    task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
        int unsigned gap;
        if (idling_on && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 10);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_reports.push_back(classify_value(value));
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // ready comes in bursts: now and then a stall, otherwise a run of ready,
    // with stalls and runs drawn from the same range of lengths
    always @(posedge i_clk) begin
        if (ready_burst == 0) begin
            i_ready     <= !(idling_on && $urandom_range(0, 2) == 0);
            ready_burst <= $urandom_range(1, 10);
        end else begin
            ready_burst <= ready_burst - 1;
        end
    end

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%s", what);
        end
    endtask

    // each result beat is matched against the oldest pending report
    always @(posedge i_clk) begin
        t_divisor_report want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_reports.size() == 0) begin
                flag_mismatch($sformatf("result beat with nothing pending: sum %0d abundant %0b by %0d",
                                        o_divisor_sum, o_is_abundant, o_abundance));
            end else begin
                want = pending_reports.pop_front();
                if (o_divisor_sum !== want.divisor_sum || o_is_abundant !== want.is_abundant ||
                    o_abundance !== want.abundance) begin
                    flag_mismatch($sformatf("result beat: expected sum %0d abundant %0b by %0d, got sum %0d abundant %0b by %0d",
                                            want.divisor_sum, want.is_abundant, want.abundance,
                                            o_divisor_sum, o_is_abundant, o_abundance));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: cycles in a row with no beat on either side
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            silent_cycles <= 0;
        end else if (silent_cycles + 1 >= SILENCE_LIMIT) begin
            $display("abundant_number_classifier_top: mismatch");
            $finish;
        end else begin
            silent_cycles <= silent_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // corners: zero and one, the smallest primes, squares where d equals its
    // cofactor, perfect numbers (sum equals value, so not abundant), even and
    // odd abundant values, a power of two, a highly composite value, and the
    // largest value the field holds, which runs the full divisor loop
    task automatic test_directed_corners();
        int unsigned corners[$];
        corners = '{0, 1, 2, 3, 4, 6, 12, 18, 20, 28, 49, 496, 945, 5040, 8128,
                    10000, 65536, 720720, 30030, 9973,
                    int'({VALUE_WIDTH{1'b1}}), 36, 2, 24};
        foreach (corners[k]) begin
            send_value(VALUE_WIDTH'(corners[k]));
        end
    endtask

    // random values, kept small since the loop cost grows with sqrt(value)
    task automatic test_random_values(input int unsigned count);
        int unsigned            pick;
        logic [VALUE_WIDTH-1:0] value;
        repeat (count) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2, 3, 4: begin
                    value = VALUE_WIDTH'($urandom_range(1, 2000));
                end
                5, 6: begin
                    // multiples of 12 are all abundant
                    value = VALUE_WIDTH'(12 * $urandom_range(1, 1500));
                end
                7: begin
                    // odd values, where abundance is rare
                    value = VALUE_WIDTH'($urandom_range(1, 30000) | 1);
                end
                8: begin
                    // perfect squares hit the equal-cofactor case
                    value = VALUE_WIDTH'($urandom_range(2, 150) ** 2);
                end
                default: begin
                    value = VALUE_WIDTH'($urandom_range(1, 65535));
                end
            endcase
            send_value(value);
        end
    endtask

    // closing stretch with no gaps and no stalls
    task automatic test_back_to_back(input int unsigned count);
        idling_on = 1'b0;
        repeat (count) begin
            send_value(VALUE_WIDTH'($urandom_range(1, 3000)));
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_value <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_random_values(51);
        test_back_to_back(25);
        i_valid <= 1'b0;

        // drain: the watchdog covers a block that never answers
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("abundant_number_classifier_top: match");
        end else begin
            $display("abundant_number_classifier_top: mismatch");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/anc_pkg.sv
src/anc_ctrl.sv
src/anc_dpath.sv
src/abundant_number_classifier_top.sv
test/tb_abundant_number_classifier_top.sv
